@@ rtl/cbmt_pkg.sv @@
// Shared types and default sizes for the counter bank with max tracking.
// No dependencies; used by counter_bank_max_tracker and its checker.
`default_nettype none

package cbmt_pkg;

  // Default sizes of the bank
  localparam int DEF_NUM_COUNTERS = 64;
  localparam int DEF_COUNT_BITS   = 16;
  localparam int DEF_STAMP_BITS   = 32;

  // Value that active_count takes at reset (clamped to the bank size)
  localparam int ACTIVE_RESET = 64;

  // Operation codes of a request
  typedef enum logic [1:0] {
    OP_INC   = 2'd0,
    OP_DEC   = 2'd1,
    OP_CLR   = 2'd2,
    OP_QUERY = 2'd3
  } op_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_UPDATE,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

@@ rtl/cbmt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module cbmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/counter_bank_max_tracker.sv @@
// Top level of the counter bank with max tracking: sequencer, update and scan unit.
// Depends on cbmt_pkg and cbmt_ram.
`default_nettype none

// A bank of NUM_COUNTERS signed saturating counters. Each request on the
// slave stream increments, decrements, zeroes or only reads one counter;
// one result per request comes out on the master stream with the counter's
// new value, the largest value among the active counters, how many hold it
// and the index of the holder whose value changed earliest. Counters and
// their change stamps share one RAM with one read port. A request with a
// valid index passes through fetch, update, scan and done; one with an
// invalid index goes straight to scan and done. The max scan reads one
// RAM entry per cycle for each counter of the effective active count
// through that single read port and feeds one shared compare unit. The
// result waits in done while the previous one is still held in the
// output register by m_tready, and no new request is taken before it is
// loaded. After reset the block first zeroes the RAM, one entry per cycle,
// with s_tready low; cfg writes are taken at any time but should only be
// made while no request is in flight.
module counter_bank_max_tracker #(
  parameter int NUM_COUNTERS = cbmt_pkg::DEF_NUM_COUNTERS,
  parameter int COUNT_BITS   = cbmt_pkg::DEF_COUNT_BITS,
  parameter int STAMP_BITS   = cbmt_pkg::DEF_STAMP_BITS,
  localparam int IDX_BITS    = $clog2(NUM_COUNTERS),
  localparam int ACT_BITS    = $clog2(NUM_COUNTERS + 1),
  localparam int IN_W        = 2 + IDX_BITS,
  localparam int IN_TW       = ((IN_W + 7) / 8) * 8,
  localparam int OUT_W       = 1 + 2 * COUNT_BITS + IDX_BITS + ACT_BITS,
  localparam int OUT_TW      = ((OUT_W + 7) / 8) * 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // configuration: active_count
  input  wire logic              cfg_we,
  input  wire logic [ACT_BITS-1:0] cfg_wdata,
  // request stream
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [IN_TW-1:0]  s_tdata,   // operation, counter_index, zero pad
  // result stream
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [OUT_TW-1:0]      m_tdata    // index_ok, counter_value, max_value,
                                            // max_index, max_holders, zero pad
);

  localparam int RAM_W = COUNT_BITS + STAMP_BITS;
  localparam int ACT_RST_I = (NUM_COUNTERS < cbmt_pkg::ACTIVE_RESET) ?
                             NUM_COUNTERS : cbmt_pkg::ACTIVE_RESET;
  localparam logic [ACT_BITS-1:0] ACT_RST = ACT_BITS'(ACT_RST_I);
  localparam logic [ACT_BITS-1:0] ACT_MAX = ACT_BITS'(NUM_COUNTERS);
  localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(NUM_COUNTERS - 1);
  localparam logic signed [COUNT_BITS-1:0] CNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
  localparam logic signed [COUNT_BITS-1:0] CNT_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};

  // state and control registers
  cbmt_pkg::state_t state, state_next;
  logic [IDX_BITS-1:0]   clr_addr;
  logic [ACT_BITS-1:0]   active_count;
  logic [STAMP_BITS-1:0] seq;
  logic                  pend;

  // request registers
  cbmt_pkg::op_t         op_r;
  logic [IDX_BITS-1:0]   idx_r;
  logic                  ok_r;
  logic [ACT_BITS-1:0]   n_r;

  // scan registers
  logic [ACT_BITS-1:0]          scan_addr;
  logic [IDX_BITS-1:0]          pend_idx;
  logic signed [COUNT_BITS-1:0] best;
  logic [STAMP_BITS-1:0]        best_stamp;
  logic [IDX_BITS-1:0]          best_idx;
  logic [ACT_BITS-1:0]          holders;
  logic signed [COUNT_BITS-1:0] value_r;

  // RAM port signals
  logic                  ram_we;
  logic [IDX_BITS-1:0]   ram_waddr;
  logic [RAM_W-1:0]      ram_wdata;
  logic [IDX_BITS-1:0]   ram_raddr;
  logic [RAM_W-1:0]      ram_rdata;

  // request decode
  cbmt_pkg::op_t         s_op;
  logic [IDX_BITS-1:0]   s_idx;
  logic [ACT_BITS-1:0]   n_eff;
  logic                  s_ok;
  logic                  accept;

  // update and compare
  logic signed [COUNT_BITS-1:0] rd_cnt;
  logic [STAMP_BITS-1:0]        rd_stamp;
  logic signed [COUNT_BITS-1:0] upd_cnt;
  logic                         changed;
  logic [STAMP_BITS-1:0]        seq_inc;
  logic                         issue;
  logic                         out_free;
  logic                         load_out;

  assign s_op  = cbmt_pkg::op_t'(s_tdata[1:0]);
  assign s_idx = s_tdata[2 +: IDX_BITS];

  // effective active count, clamped to 1..NUM_COUNTERS
  always_comb begin
    if (active_count == '0) begin
      n_eff = ACT_BITS'(1);
    end else if (active_count > ACT_MAX) begin
      n_eff = ACT_MAX;
    end else begin
      n_eff = active_count;
    end
  end

  assign s_ok = ACT_BITS'(s_idx) < n_eff;

  assign rd_cnt   = ram_rdata[COUNT_BITS-1:0];
  assign rd_stamp = ram_rdata[RAM_W-1:COUNT_BITS];
  assign seq_inc  = seq + 1'b1;
  assign issue    = scan_addr < n_r;
  assign out_free = !m_tvalid || m_tready;

  // saturating update of the addressed counter
  always_comb begin
    unique case (op_r)
      cbmt_pkg::OP_INC: begin
        changed = rd_cnt != CNT_MAX;
        upd_cnt = changed ? rd_cnt + 1'b1 : rd_cnt;
      end
      cbmt_pkg::OP_DEC: begin
        changed = rd_cnt != CNT_MIN;
        upd_cnt = changed ? rd_cnt - 1'b1 : rd_cnt;
      end
      cbmt_pkg::OP_CLR: begin
        changed = rd_cnt != '0;
        upd_cnt = '0;
      end
      default: begin
        changed = 1'b0;
        upd_cnt = rd_cnt;
      end
    endcase
  end

  // sequencer: next state and strobes
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    accept     = 1'b0;
    ram_we     = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      cbmt_pkg::ST_CLEAR: begin
        ram_we = 1'b1;
        if (clr_addr == LAST_IDX) begin
          state_next = cbmt_pkg::ST_IDLE;
        end
      end
      cbmt_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          accept     = 1'b1;
          state_next = s_ok ? cbmt_pkg::ST_FETCH : cbmt_pkg::ST_SCAN;
        end
      end
      cbmt_pkg::ST_FETCH: begin
        state_next = cbmt_pkg::ST_UPDATE;
      end
      cbmt_pkg::ST_UPDATE: begin
        ram_we     = changed;
        state_next = cbmt_pkg::ST_SCAN;
      end
      cbmt_pkg::ST_SCAN: begin
        if (!issue && !pend) begin
          state_next = cbmt_pkg::ST_DONE;
        end
      end
      cbmt_pkg::ST_DONE: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = cbmt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = cbmt_pkg::ST_IDLE;
      end
    endcase
  end

  // RAM address and data selection
  assign ram_waddr = (state == cbmt_pkg::ST_CLEAR) ? clr_addr : idx_r;
  assign ram_wdata = (state == cbmt_pkg::ST_CLEAR) ? '0 : {seq_inc, upd_cnt};
  assign ram_raddr = (state == cbmt_pkg::ST_FETCH) ? idx_r : scan_addr[IDX_BITS-1:0];

  cbmt_ram #(
    .WIDTH (RAM_W),
    .DEPTH (NUM_COUNTERS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= cbmt_pkg::ST_CLEAR;
      clr_addr     <= '0;
      active_count <= ACT_RST;
      seq          <= '0;
      pend         <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      state <= state_next;
      if (state == cbmt_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cfg_we) begin
        active_count <= cfg_wdata;
      end
      if (state == cbmt_pkg::ST_UPDATE && changed) begin
        seq <= seq_inc;
      end
      pend <= (state == cbmt_pkg::ST_SCAN) && issue;
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // request capture, update result and scan datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r      <= s_op;
      idx_r     <= s_idx;
      ok_r      <= s_ok;
      n_r       <= n_eff;
      scan_addr <= '0;
      holders   <= '0;
      value_r   <= '0;
    end
    if (state == cbmt_pkg::ST_UPDATE) begin
      value_r <= upd_cnt;
    end
    // issue one read per cycle
    if (state == cbmt_pkg::ST_SCAN && issue) begin
      scan_addr <= scan_addr + 1'b1;
      pend_idx  <= scan_addr[IDX_BITS-1:0];
    end
    // shared compare on the entry read last cycle
    if (pend) begin
      if (holders == '0 || rd_cnt > best) begin
        best       <= rd_cnt;
        best_stamp <= rd_stamp;
        best_idx   <= pend_idx;
        holders    <= ACT_BITS'(1);
      end else if (rd_cnt == best) begin
        holders <= holders + 1'b1;
        if (rd_stamp < best_stamp) begin
          best_stamp <= rd_stamp;
          best_idx   <= pend_idx;
        end
      end
    end
    // result register
    if (load_out) begin
      m_tdata <= OUT_TW'({holders, best_idx, best, value_r, ok_r});
    end
  end

endmodule

`default_nettype wire

@@ rtl/cbmt_checker.sv @@
// Port-level checks for counter_bank_max_tracker, attached by bind.
// Depends on cbmt_pkg for default sizes.
`default_nettype none

module cbmt_checker #(
  parameter int NUM_COUNTERS = cbmt_pkg::DEF_NUM_COUNTERS,
  parameter int COUNT_BITS   = cbmt_pkg::DEF_COUNT_BITS,
  localparam int IDX_BITS    = $clog2(NUM_COUNTERS),
  localparam int ACT_BITS    = $clog2(NUM_COUNTERS + 1),
  localparam int OUT_W       = 1 + 2 * COUNT_BITS + IDX_BITS + ACT_BITS,
  localparam int OUT_TW      = ((OUT_W + 7) / 8) * 8
) (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              s_tvalid,
  input wire logic              s_tready,
  input wire logic              m_tvalid,
  input wire logic              m_tready,
  input wire logic [OUT_TW-1:0] m_tdata
);

  logic                         r_ok;
  logic signed [COUNT_BITS-1:0] r_value;
  logic signed [COUNT_BITS-1:0] r_max;
  logic [ACT_BITS-1:0]          r_holders;

  assign r_ok      = m_tdata[0];
  assign r_value   = m_tdata[1 +: COUNT_BITS];
  assign r_max     = m_tdata[1 + COUNT_BITS +: COUNT_BITS];
  assign r_holders = m_tdata[1 + 2 * COUNT_BITS + IDX_BITS +: ACT_BITS];

  // one request at a time: busy right after taking one
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while previous one still in work");

  // stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // ignored request reports a zero counter value
  a_bad_index_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !r_ok |-> r_value == '0)
    else $error("nonzero counter value for out-of-range index");

  // at least one counter always holds the maximum
  a_holders_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> r_holders != '0)
    else $error("max holder count is zero");

  // the addressed active counter never exceeds the maximum
  a_value_le_max: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && r_ok |-> r_value <= r_max)
    else $error("counter value above reported maximum");

endmodule

bind counter_bank_max_tracker cbmt_checker #(
  .NUM_COUNTERS (NUM_COUNTERS),
  .COUNT_BITS   (COUNT_BITS)
) u_cbmt_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

@@ tb/cbmt_max_checker.sv @@
// Checker for counter_bank_max_tracker: watches the config port and both streams,
// predicts every result and compares it field by field. Depends on cbmt_pkg.
module cbmt_max_checker
  import cbmt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,    // operation, counter_index
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [47:0] m_tdata,    // index_ok, counter_value, max_value, max_index, max_holders
  output int          fail_count,
  output int          pending,
  output int          checked_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM    = DEF_NUM_COUNTERS;
  localparam int CNT_HI = 2 ** (DEF_COUNT_BITS - 1) - 1;
  localparam int CNT_LO = -CNT_HI - 1;
  localparam int REPORT_LIMIT = 10;

  // Result layout, declared from the top bit down so it overlays m_tdata[45:0]
  typedef struct packed {
    logic [6:0]         holders;
    logic [5:0]         max_idx;
    logic signed [15:0] max_val;
    logic signed [15:0] cnt_val;
    logic               ok;
  } result_t;

  // Shadow copy of the counter bank
  int          bank_val[NUM];
  logic [31:0] bank_stamp[NUM];
  logic [31:0] seq_num;
  logic [6:0]  active_reg;

  result_t expected_results[$];
  result_t exp_r, got_r;
  int      fails, checked;

  function automatic void stamp_counter(int k);
    seq_num     = seq_num + 1;
    bank_stamp[k] = seq_num;
  endfunction

  // Apply one request to the shadow bank and scan for the maximum
  function automatic result_t predict_result(op_t op, logic [5:0] idx);
    int          n;
    int          best;
    int          best_k;
    int          holders;
    logic [31:0] best_stamp;
    result_t     r;
    n = (active_reg == 0) ? 1 : (active_reg > NUM) ? NUM : int'(active_reg);
    r = '0;
    r.ok = (int'(idx) < n);
    if (r.ok) begin
      case (op)
        OP_INC: begin
          if (bank_val[idx] < CNT_HI) begin
            bank_val[idx]++;
            stamp_counter(idx);
          end
        end
        OP_DEC: begin
          if (bank_val[idx] > CNT_LO) begin
            bank_val[idx]--;
            stamp_counter(idx);
          end
        end
        OP_CLR: begin
          if (bank_val[idx] != 0) begin
            bank_val[idx] = 0;
            stamp_counter(idx);
          end
        end
        default: ;
      endcase
      r.cnt_val = 16'(bank_val[idx]);
    end
    // earliest stamp wins among holders; strict compare keeps the lower index on ties
    best = 0;
    best_k = 0;
    holders = 0;
    best_stamp = '0;
    for (int k = 0; k < n; k++) begin
      if (holders == 0 || bank_val[k] > best) begin
        best = bank_val[k];
        best_stamp = bank_stamp[k];
        best_k = k;
        holders = 1;
      end else if (bank_val[k] == best) begin
        holders++;
        if (bank_stamp[k] < best_stamp) begin
          best_stamp = bank_stamp[k];
          best_k = k;
        end
      end
    end
    r.max_val = 16'(best);
    r.max_idx = 6'(best_k);
    r.holders = 7'(holders);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM; k++) begin
        bank_val[k] = 0;
        bank_stamp[k] = '0;
      end
      seq_num = '0;
      active_reg = 7'(ACTIVE_RESET);
      expected_results.delete();
      fails = 0;
      checked = 0;
    end else begin
      // result side: compare with the oldest prediction
      if (m_tvalid && m_tready) begin
        got_r = result_t'(m_tdata[45:0]);
        if (expected_results.size() == 0) begin
          fails++;
          if (fails <= REPORT_LIMIT)
            $display("[%0t] result with no request pending: %s",
                     $realtime,
                     $sformatf("ok=%0d val=%0d max=%0d idx=%0d n=%0d",
                               got_r.ok, got_r.cnt_val, got_r.max_val,
                               got_r.max_idx, got_r.holders));
        end else begin
          exp_r = expected_results.pop_front();
          if (got_r.ok != exp_r.ok || got_r.cnt_val != exp_r.cnt_val ||
              got_r.max_val != exp_r.max_val || got_r.max_idx != exp_r.max_idx ||
              got_r.holders != exp_r.holders) begin
            fails++;
            if (fails <= REPORT_LIMIT)
              $display("[%0t] result %0d: exp %s, got %s",
                       $realtime, checked,
                       $sformatf("ok=%0d val=%0d max=%0d idx=%0d n=%0d",
                                 exp_r.ok, exp_r.cnt_val, exp_r.max_val,
                                 exp_r.max_idx, exp_r.holders),
                       $sformatf("ok=%0d val=%0d max=%0d idx=%0d n=%0d",
                                 got_r.ok, got_r.cnt_val, got_r.max_val,
                                 got_r.max_idx, got_r.holders));
          end
        end
        checked++;
      end
      if (cfg_we)
        active_reg = cfg_wdata;
      // request side
      if (s_tvalid && s_tready)
        expected_results.insert(expected_results.size(),
                                predict_result(op_t'(s_tdata[1:0]), s_tdata[7:2]));
    end
    fail_count    <= fails;
    pending       <= expected_results.size();
    checked_count <= checked;
  end

endmodule

@@ tb/tb_counter_bank_max_tracker.sv @@
// Testbench top for counter_bank_max_tracker: clock, reset, request and result
// traffic, config writes and the verdict. Depends on cbmt_pkg and cbmt_max_checker.
module tb_counter_bank_max_tracker;
  timeunit 1ns;
  timeprecision 1ps;
  import cbmt_pkg::*;

  localparam int NUM          = DEF_NUM_COUNTERS;
  localparam int BURST_ITEMS  = 10;
  localparam int LIMIT_CYCLES = 3_000_000;
  localparam int HOLD_CYCLES  = 500;
  localparam int SEG_ITEMS    = 50;
  localparam int DRAIN_CYCLES = 80;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [6:0]  cfg_wdata;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;    // operation, counter_index
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;    // index_ok, counter_value, max_value, max_index, max_holders, pad

  int fail_count, pending, checked_count;
  int sent, cfg_writes, cycle_count;
  bit rx_full_speed;
  bit hold_off_req;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  counter_bank_max_tracker i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  cbmt_max_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .fail_count    (fail_count),
    .pending       (pending),
    .checked_count (checked_count)
  );

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("run stopped: cycle limit reached with %0d results outstanding", pending);
      $display("Some tests failed");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(25, 90);
  endfunction

  // Result side: random ready, full speed, or one long hold-off on request
  initial begin
    int unsigned r;
    m_tready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else if (rx_full_speed) begin
        m_tready <= 1'b1;
        @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          m_tready <= 1'b1;
          repeat ($urandom_range(1, 12)) @(posedge clk);
        end else if (r < 94) begin
          m_tready <= 1'b0;
          repeat ($urandom_range(1, 4)) @(posedge clk);
        end else begin
          m_tready <= 1'b0;
          repeat ($urandom_range(15, 60)) @(posedge clk);
        end
      end
    end
  end

  // One request, then an optional idle gap
  task automatic send_req(input op_t op, input logic [5:0] idx, input int unsigned gap);
    s_tvalid <= 1'b1;
    s_tdata  <= {idx, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Write active_count once all outstanding results are back
  task automatic set_active(input logic [6:0] value);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_writes++;
  endtask

  task automatic send_random(input op_t op, input logic [5:0] idx);
    send_req(op, idx, pick_gap());
  endtask

  initial begin
    logic [6:0] seg_active[8];
    int unsigned r, n_eff, burst;
    op_t op;
    logic [5:0] idx;

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    sent = 0;
    cfg_writes = 0;
    cycle_count = 0;
    rx_full_speed = 1'b0;
    hold_off_req = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset state, tie breaking, clears, out-of-range indices, clamping
    send_random(OP_QUERY, 6'd0);      // all zero, all stamps equal
    send_random(OP_INC, 6'd63);
    send_random(OP_INC, 6'd5);        // tie at 1, counter 63 got there first
    send_random(OP_DEC, 6'd0);
    send_random(OP_DEC, 6'd0);
    send_random(OP_CLR, 6'd0);        // nonzero counter back to zero
    send_random(OP_CLR, 6'd1);        // already zero, keeps its stamp
    send_random(OP_INC, 6'd0);
    send_random(OP_QUERY, 6'd63);
    send_random(OP_CLR, 6'd63);
    send_random(OP_DEC, 6'd5);
    set_active(7'd3);
    send_random(OP_QUERY, 6'd63);     // outside the active range
    send_random(OP_INC, 6'd40);
    send_random(OP_INC, 6'd2);
    send_random(OP_QUERY, 6'd2);
    set_active(7'd0);                 // behaves as one counter
    send_random(OP_INC, 6'd0);
    send_random(OP_QUERY, 6'd1);
    send_random(OP_DEC, 6'd0);
    set_active(7'd127);               // clamps to the bank size
    send_random(OP_QUERY, 6'd62);
    send_random(OP_INC, 6'd62);
    set_active(7'd65);
    send_random(OP_QUERY, 6'd62);

    // Back-to-back requests on one active counter, receiver always ready
    set_active(7'd1);
    rx_full_speed = 1'b1;
    send_req(OP_CLR, 6'd0, 0);
    for (int k = 0; k < BURST_ITEMS; k++)
      send_req(OP_INC, 6'd0, 0);
    send_req(OP_CLR, 6'd0, 0);
    for (int k = 0; k < BURST_ITEMS; k++)
      send_req(OP_DEC, 6'd0, 0);
    send_req(OP_CLR, 6'd0, 0);
    rx_full_speed = 1'b0;

    // Random segments over several active counts
    seg_active[0] = 7'd64;
    seg_active[1] = 7'd2;
    seg_active[2] = 7'd17;
    seg_active[3] = 7'd0;
    seg_active[4] = 7'd127;
    seg_active[5] = 7'($urandom_range(1, NUM));
    seg_active[6] = 7'd33;
    seg_active[7] = 7'd64;
    for (int seg = 0; seg < 8; seg++) begin
      set_active(seg_active[seg]);
      n_eff = (seg_active[seg] == 0) ? 1 : (seg_active[seg] > NUM) ? NUM : seg_active[seg];
      rx_full_speed = (seg == 6);
      burst = 0;
      for (int k = 0; k < SEG_ITEMS; k++) begin
        // long receiver hold-off while requests keep coming
        if (seg == 1 && k == 10) begin
          hold_off_req = 1'b1;
          burst = 10;
        end
        r = $urandom_range(0, 99);
        op = (r < 40) ? OP_INC : (r < 62) ? OP_DEC : (r < 72) ? OP_CLR : OP_QUERY;
        r = $urandom_range(0, 99);
        if (r < 10)
          idx = 6'($urandom_range(0, NUM - 1));
        else if (r < 55)
          idx = 6'($urandom_range(0, ((n_eff < 8) ? n_eff : 8) - 1));
        else
          idx = 6'($urandom_range(0, n_eff - 1));
        if (burst != 0) begin
          burst--;
          send_req(op, idx, 0);
        end else begin
          send_random(op, idx);
        end
      end
    end

    // Drain and settle
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests and %0d active-count writes, incl. ties and clears,",
             sent, cfg_writes);
    $display("out-of-range indices, clamped counts and a long result stall; %0d results checked.",
             checked_count);
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
